// ----- hw/rtl/elp_pkg.sv -----
package elp_pkg;

   // default sample width, Q1.(SAMPLE_BITS-1)
   localparam int SAMPLE_BITS_DEF = 24;

   // configuration register index
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ATTACK    = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RELEASE   = 2'd2;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/elp_mul.sv -----
module elp_mul #(
   parameter int WIDTH = elp_pkg::SAMPLE_BITS_DEF + 1
) (
   input  logic                        clock,
   input  logic signed [WIDTH-1:0]     mul_a,
   input  logic signed [WIDTH-1:0]     mul_b,
   output logic signed [2*WIDTH-1:0]   product
);
   import elp_pkg::*;

   logic signed [2*WIDTH-1:0] product_in;
   logic signed [2*WIDTH-1:0] product_ff;

   // register every product before it is used
   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- hw/rtl/elp_div.sv -----
module elp_div #(
   parameter int N = elp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [2*N-1:0]                   dividend,
   input  logic [N-1:0]                     divisor,
   output elp_pkg::div_status_type          status,
   output logic [N-1:0]                     quotient
);
   import elp_pkg::*;

   localparam int CNT_BITS = $clog2(N + 1);

   logic [N-1:0]        rem_ff;
   logic [N-1:0]        quo_ff;
   logic [N-1:0]        den_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [N:0]          shifted;
   logic [N+1:0]        trial;
   logic                fits;

   // one quotient bit per cycle: shift in the next dividend bit, try subtract
   assign shifted = {rem_ff, quo_ff[N-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~trial[N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(N);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[2*N-1:N];
         quo_ff <= dividend[N-1:0];
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[N-1:0] : shifted[N-1:0];
         quo_ff <= {quo_ff[N-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- hw/rtl/envelope_peak_limiter.sv -----
// Envelope peak limiter, one sample per request, one response per request.
// The result takes a bypass path when the envelope stays at or below the
// threshold and the divider path when limiting (the restoring divider makes one
// quotient bit per cycle). The next request is taken only once the result of the
// last one is loaded into the response register, so requests never overlap.
// Reset (synchronous, active high) clears the envelope and loads the defaults.
module envelope_peak_limiter #(
   parameter int SAMPLE_BITS = elp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,   // sample_in
   // response channel
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,   // sample_out
   output logic                                     rsp_tuser,   // limiting_active
   // configuration writes
   input  logic                                     csr_we,
   input  logic [elp_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [SAMPLE_BITS-1:0]                   csr_wdata
);
   import elp_pkg::*;

   localparam int N     = SAMPLE_BITS;
   localparam int DBITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int W     = N + 1;     // signed multiplier operand width

   localparam logic [N-1:0] FULL_SCALE = {1'b1, {(N-1){1'b0}}};
   localparam logic [63:0]  FS64       = 64'd1 << (N - 1);
   localparam logic [63:0]  THR_RST64  = (64'd9 * FS64 + 64'd5) / 64'd10;
   localparam logic [63:0]  ATT_RST64  = (FS64 + 64'd500) / 64'd1000;
   localparam logic [63:0]  REL_RST64  = (FS64 + 64'd5000) / 64'd10000;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;   // coeff * (mag - env)
   localparam logic [2:0] S_ENV  = 3'd2;   // envelope update
   localparam logic [2:0] S_MUL2 = 3'd3;   // mag * threshold, threshold compare
   localparam logic [2:0] S_DIVS = 3'd4;   // start divider or bypass
   localparam logic [2:0] S_DIVW = 3'd5;   // wait for quotient
   localparam logic [2:0] S_OUT  = 3'd6;   // hand result to response register

   logic [2:0]   state_ff, state_in;

   // configuration
   logic [N-1:0] thr_ff, att_ff, rel_ff;
   logic [N-1:0] att_sat, rel_sat;

   // envelope
   logic [N-1:0] env_ff;

   // per-request working registers
   logic [N-1:0]        x_ff, mag_ff, coeff_ff;
   logic signed [N:0]   diff_ff;
   logic                lim_ff;

   logic [N-1:0]        x_in, mag_in, coeff_in;
   logic signed [N:0]   diff_in;

   // shared multiplier
   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [2*W-1:0] product;

   // envelope update path
   logic signed [2*W-1:0] step_full;
   logic signed [N+1:0]   env_sum;
   logic [N-1:0]          env_new;

   // divider
   logic                  div_start;
   div_status_type        div_status;
   logic [N-1:0]          div_quo;

   // response register
   logic                  rsp_valid_ff;
   logic [N-1:0]          rsp_data_ff;
   logic                  rsp_user_ff;
   logic [N-1:0]          result;
   logic                  rsp_load;

   logic                  req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // coefficients above full scale saturate to 1.0
   assign att_sat = (att_ff > FULL_SCALE) ? FULL_SCALE : att_ff;
   assign rel_sat = (rel_ff > FULL_SCALE) ? FULL_SCALE : rel_ff;

   // capture: magnitude (most negative maps to full scale), direction, error
   assign x_in     = req_tdata[N-1:0];
   assign mag_in   = x_in[N-1] ? (~x_in + 1'b1) : x_in;
   assign coeff_in = (mag_in > env_ff) ? att_sat : rel_sat;
   assign diff_in  = $signed({1'b0, mag_in}) - $signed({1'b0, env_ff});

   // operand select for the shared multiplier
   assign mul_a = (state_ff == S_MUL2) ? $signed({1'b0, mag_ff}) : $signed({1'b0, coeff_ff});
   assign mul_b = (state_ff == S_MUL2) ? $signed({1'b0, thr_ff}) : diff_ff;

   elp_mul #(
      .WIDTH (W)
   ) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // floor shift back to Q0.(N-1), then add and clamp to [0, full scale]
   assign step_full = product >>> (N - 1);
   assign env_sum   = $signed({2'b00, env_ff}) + step_full[N+1:0];

   always_comb begin
      if (env_sum[N+1]) begin
         env_new = '0;
      end else if (env_sum[N:0] > {1'b0, FULL_SCALE}) begin
         env_new = FULL_SCALE;
      end else begin
         env_new = env_sum[N-1:0];
      end
   end

   // mag * threshold < 2^(2N); quotient does not exceed mag when limiting
   assign div_start = (state_ff == S_DIVS) && lim_ff;

   elp_div #(
      .N (N)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product[2*N-1:0]),
      .divisor  (env_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   // restore the sign of the quotient; pass the sample when not limiting
   assign result   = lim_ff ? (x_ff[N-1] ? (~div_quo + 1'b1) : div_quo) : x_ff;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_MUL1;
         end
         S_MUL1: state_in = S_ENV;
         S_ENV:  state_in = S_MUL2;
         S_MUL2: state_in = S_DIVS;
         S_DIVS: state_in = lim_ff ? S_DIVW : S_OUT;
         S_DIVW: begin
            if (div_status.done && !div_status.busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RST64[N-1:0];
         att_ff <= ATT_RST64[N-1:0];
         rel_ff <= REL_RST64[N-1:0];
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_THRESHOLD: thr_ff <= csr_wdata;
            REG_ATTACK:    att_ff <= csr_wdata;
            REG_RELEASE:   rel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // envelope: clear on reset, advance once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else if (state_ff == S_ENV) begin
         env_ff <= env_new;
      end
   end

   // hold the request and its derived terms
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff     <= x_in;
         mag_ff   <= mag_in;
         coeff_ff <= coeff_in;
         diff_ff  <= diff_in;
      end
      // envelope already updated here
      if (state_ff == S_MUL2) begin
         lim_ff <= (env_ff > thr_ff);
      end
   end

   // response register: drop valid when taken, load when the result is ready
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
         rsp_user_ff <= lim_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DBITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- hw/rtl/elp_checker.sv -----
module elp_checker #(
   parameter int SAMPLE_BITS = elp_pkg::SAMPLE_BITS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   input logic                                 rsp_tuser
);
   import elp_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset leaves the block idle with no response pending
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // no response can follow a request in the very next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response too early");

endmodule

bind envelope_peak_limiter elp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_elp_checker (.*);
